>>> hw/rtl/ray_triangle_intersect_defines.svh
// Assertion macros shared by the ray/triangle intersection RTL.
`ifndef RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_DEFINES_SVH

// Checked at every clock edge while the block is out of reset.
`define RTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define RTI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hw/rtl/rti_pkg.sv
// Types, widths and constants of the ray/triangle intersection pipeline.
package rti_pkg;

  // Coordinate format.
  localparam int CW  = 32;
  localparam int FB  = 16;
  localparam int TW  = 31;
  // Edge, cross product and dot product widths.
  localparam int EW  = CW + 1;
  localparam int PW  = 2 * EW;
  localparam int XW  = PW + 1;
  localparam int LOW = 34;
  localparam int HIW = XW - LOW;
  localparam int PLW = EW + LOW + 1;
  localparam int DW  = EW + XW + 3;
  localparam int AMW = DW - 1;
  // Distance test and division widths.
  localparam int NCH = 3;
  localparam int CH  = (AMW + NCH - 1) / NCH;
  localparam int PTW = TW + CH;
  localparam int MW  = TW + CH * NCH;
  localparam int XSW = AMW + FB;
  localparam int QB  = TW;
  localparam int RW  = AMW + QB + 1;
  localparam int CIW = 3;

  localparam logic [TW-1:0] HIT_MAX = {TW{1'b1}};

  typedef logic [CW-1:0]       cw_t;
  typedef cw_t  [2:0]          cw3_t;
  typedef logic [EW-1:0]       ev_t;
  typedef ev_t  [2:0]          ev3_t;
  typedef logic [XW-1:0]       xv_t;
  typedef xv_t  [2:0]          xv3_t;
  typedef logic [DW-1:0]       dv_t;

  typedef struct packed {
    cw3_t            org;
    cw3_t            dir;
    logic [TW-1:0]   thr;
  } ray_cfg_t;

  typedef enum logic [CIW-1:0] {
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_ORIGIN_Z,
    CFG_DIR_X,
    CFG_DIR_Y,
    CFG_DIR_Z,
    CFG_THRESHOLD
  } cfg_idx_e;

  // Neighbors in a cross product.
  localparam int IP1 [3] = '{1, 2, 0};
  localparam int IP2 [3] = '{2, 0, 1};

  // Sign extension of a coordinate to edge width.
  function automatic ev_t sx(input cw_t c);
    return {c[CW-1], c};
  endfunction

endpackage

>>> hw/rtl/rti_ifs.sv
// Channel interfaces: triangle input, hit result and configuration writes.
interface rti_tri_if;
  import rti_pkg::*;
  logic            valid;
  logic            ready;
  logic signed [CW-1:0] vert0_x, vert0_y, vert0_z;
  logic signed [CW-1:0] vert1_x, vert1_y, vert1_z;
  logic signed [CW-1:0] vert2_x, vert2_y, vert2_z;
  modport source (output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                  vert2_x, vert2_y, vert2_z, input ready);
  modport sink (input valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                vert2_x, vert2_y, vert2_z, output ready);
endinterface

interface rti_hit_if;
  import rti_pkg::*;
  logic          valid;
  logic          ready;
  logic          hit;
  logic [TW-1:0] hit_distance;
  modport source (output valid, hit, hit_distance, input ready);
  modport sink (input valid, hit, hit_distance, output ready);
endinterface

interface rti_cfg_if;
  import rti_pkg::*;
  logic           valid;
  logic           ready;
  logic [CIW-1:0] index;
  logic [CW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/rti_front.sv
// Edge vectors and the two cross products h and q, in three stages.
module rti_front import rti_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  cw3_t     v0_i,
  input  cw3_t     v1_i,
  input  cw3_t     v2_i,
  input  ray_cfg_t cfg_i,
  output logic     valid_o,
  input  logic     ready_i,
  output ev3_t     e1_o,
  output ev3_t     e2_o,
  output ev3_t     s_o,
  output xv3_t     h_o,
  output xv3_t     q_o
);

  logic [2:0] v_q;
  logic [2:0] en;
  ev3_t e1_q [2], e2_q [2], s_q [2];
  ev3_t e1_d, e2_d, s_d;
  logic [PW-1:0] hpa_q [3], hpb_q [3], qpa_q [3], qpb_q [3];
  logic [PW-1:0] hpa_d [3], hpb_d [3], qpa_d [3], qpb_d [3];
  xv3_t h_q, q_q, h_d, q_d;

  // Stage enables: a stage moves when it is empty or the next one moves.
  assign en[2]   = !v_q[2] || ready_i;
  assign en[1]   = !v_q[1] || en[2];
  assign en[0]   = !v_q[0] || en[1];
  assign ready_o = en[0];

  // Stage one: edges and the origin offset.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1_d[k] = sx(v1_i[k]) - sx(v0_i[k]);
      e2_d[k] = sx(v2_i[k]) - sx(v0_i[k]);
      s_d[k]  = sx(cfg_i.org[k]) - sx(v0_i[k]);
    end
  end

  // Stage two: the twelve products of h = dir x e2 and q = s x e1.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hpa_d[k] = PW'($signed(sx(cfg_i.dir[IP1[k]])) * $signed(e2_q[0][IP2[k]]));
      hpb_d[k] = PW'($signed(sx(cfg_i.dir[IP2[k]])) * $signed(e2_q[0][IP1[k]]));
      qpa_d[k] = PW'($signed(s_q[0][IP1[k]]) * $signed(e1_q[0][IP2[k]]));
      qpb_d[k] = PW'($signed(s_q[0][IP2[k]]) * $signed(e1_q[0][IP1[k]]));
    end
  end

  // Stage three: differences of the products.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      h_d[k] = {hpa_q[k][PW-1], hpa_q[k]} - {hpb_q[k][PW-1], hpb_q[k]};
      q_d[k] = {qpa_q[k][PW-1], qpa_q[k]} - {qpb_q[k][PW-1], qpb_q[k]};
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      e1_q[0] <= e1_d;
      e2_q[0] <= e2_d;
      s_q[0]  <= s_d;
    end
    if (en[1]) begin
      e1_q[1] <= e1_q[0];
      e2_q[1] <= e2_q[0];
      s_q[1]  <= s_q[0];
      hpa_q   <= hpa_d;
      hpb_q   <= hpb_d;
      qpa_q   <= qpa_d;
      qpb_q   <= qpb_d;
    end
    if (en[2]) begin
      e1_o <= e1_q[1];
      e2_o <= e2_q[1];
      s_o  <= s_q[1];
      h_q  <= h_d;
      q_q  <= q_d;
    end
  end

  assign valid_o = v_q[2];
  assign h_o     = h_q;
  assign q_o     = q_q;

endmodule

>>> hw/rtl/rti_dot.sv
// Dot products for the determinant and the u, v and t numerators.
module rti_dot import rti_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  ev3_t     e1_i,
  input  ev3_t     e2_i,
  input  ev3_t     s_i,
  input  xv3_t     h_i,
  input  xv3_t     q_i,
  input  cw3_t     dir_i,
  output logic     valid_o,
  input  logic     ready_i,
  output dv_t      det_o,
  output dv_t      un_o,
  output dv_t      vn_o,
  output dv_t      tn_o
);

  logic [2:0]     v_q;
  logic [2:0]     en;
  logic [PLW-1:0] plo_q [12], plo_d [12];
  logic [PW-1:0]  phi_q [12], phi_d [12];
  dv_t            prod_q [12], prod_d [12];
  dv_t            sum_q [4], sum_d [4];

  assign en[2]   = !v_q[2] || ready_i;
  assign en[1]   = !v_q[1] || en[2];
  assign en[0]   = !v_q[0] || en[1];
  assign ready_o = en[0];

  // Stage one: each term split into a low and a high partial product.
  always_comb begin
    ev_t lf [12];
    xv_t rt [12];
    for (int k = 0; k < 3; k++) begin
      lf[k]     = e1_i[k];
      rt[k]     = h_i[k];
      lf[3 + k] = s_i[k];
      rt[3 + k] = h_i[k];
      lf[6 + k] = sx(dir_i[k]);
      rt[6 + k] = q_i[k];
      lf[9 + k] = e2_i[k];
      rt[9 + k] = q_i[k];
    end
    for (int t = 0; t < 12; t++) begin
      plo_d[t] = PLW'($signed(lf[t]) * $signed({1'b0, rt[t][LOW-1:0]}));
      phi_d[t] = PW'($signed(lf[t]) * $signed(rt[t][XW-1:LOW]));
    end
  end

  // Stage two: recombine the partial products.
  always_comb begin
    logic signed [DW-1:0] wh, wl;
    wh = '0;
    wl = '0;
    for (int t = 0; t < 12; t++) begin
      wh        = $signed(phi_q[t]);
      wl        = $signed(plo_q[t]);
      prod_d[t] = (wh <<< LOW) + wl;
    end
  end

  // Stage three: three-term sums.
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      sum_d[g] = prod_q[3 * g] + prod_q[3 * g + 1] + prod_q[3 * g + 2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
    if (en[1]) prod_q <= prod_d;
    if (en[2]) sum_q <= sum_d;
  end

  assign valid_o = v_q[2];
  assign det_o   = sum_q[0];
  assign un_o    = sum_q[1];
  assign vn_o    = sum_q[2];
  assign tn_o    = sum_q[3];

endmodule

>>> hw/rtl/rti_test.sv
// Sign normalization, triangle and distance tests, division setup.
module rti_test import rti_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  dv_t           det_i,
  input  dv_t           un_i,
  input  dv_t           vn_i,
  input  dv_t           tn_i,
  input  logic [TW-1:0] thr_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic          hit_o,
  output logic          sat_o,
  output logic [RW-1:0] rem_o,
  output logic [AMW-1:0] div_o
);

  logic [2:0]      v_q;
  logic [2:0]      en;
  dv_t             a_q, un_q, vn_q, tn_q;
  logic            neg;
  logic            fail_q, fail_d;
  logic [PTW-1:0]  pt_q [NCH], pt_d [NCH];
  logic [XSW-1:0]  x_q;
  logic [AMW-1:0]  am_q, am2_q;
  logic [MW-1:0]   prod;
  logic            hit_q, sat_q;
  logic [XSW-1:0]  x2_q;

  assign en[2]   = !v_q[2] || ready_i;
  assign en[1]   = !v_q[1] || en[2];
  assign en[0]   = !v_q[0] || en[1];
  assign ready_o = en[0];
  assign neg     = det_i[DW-1];

  // Stage two: parallel, barycentric and sign tests; threshold times determinant.
  always_comb begin
    logic signed [DW:0] uv;
    logic [AMW-1:0]     am;
    logic [AMW-1:0]     eps;
    uv  = $signed(un_q) + $signed(vn_q);
    am  = a_q[AMW-1:0];
    eps = AMW'({thr_i, {(2 * FB){1'b0}}});
    fail_d = (am == '0) || (am < eps)
          || un_q[DW-1] || ($signed(a_q) < $signed(un_q))
          || vn_q[DW-1] || ($signed({a_q[DW-1], a_q}) < uv)
          || tn_q[DW-1] || (tn_q == '0);
    for (int c = 0; c < NCH; c++) begin
      pt_d[c] = PTW'(thr_i) * PTW'(am[c * CH +: CH]);
    end
  end

  // Stage three: full product, distance test and saturation check.
  always_comb begin
    prod = '0;
    for (int c = 0; c < NCH; c++) begin
      prod = prod + (MW'(pt_q[c]) << (c * CH));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    // Stage one: make the determinant non-negative.
    if (en[0]) begin
      a_q  <= neg ? -det_i : det_i;
      un_q <= neg ? -un_i  : un_i;
      vn_q <= neg ? -vn_i  : vn_i;
      tn_q <= neg ? -tn_i  : tn_i;
    end
    if (en[1]) begin
      fail_q <= fail_d;
      pt_q   <= pt_d;
      x_q    <= {tn_q[AMW-1:0], {FB{1'b0}}};
      am_q   <= a_q[AMW-1:0];
    end
    if (en[2]) begin
      hit_q <= !fail_q && (prod < MW'(x_q));
      sat_q <= RW'(x_q) >= (RW'(am_q) << QB);
      x2_q  <= x_q;
      am2_q <= am_q;
    end
  end

  assign valid_o = v_q[2];
  assign hit_o   = hit_q;
  assign sat_o   = sat_q;
  assign rem_o   = RW'(x2_q);
  assign div_o   = am2_q;

endmodule

>>> hw/rtl/rti_div.sv
// Restoring divider for the hit distance, one quotient bit per stage.
module rti_div import rti_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic           hit_i,
  input  logic           sat_i,
  input  logic [RW-1:0]  rem_i,
  input  logic [AMW-1:0] div_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic           hit_o,
  output logic [TW-1:0]  dist_o
);

  logic [QB-1:0]  v_q;
  logic [QB-1:0]  en;
  logic [QB-1:0]  hit_q, sat_q;
  logic [RW-1:0]  rem_q [QB];
  logic [AMW-1:0] dv_q  [QB];
  logic [TW-1:0]  quo_q [QB];

  // Enable chain from the output back to the input.
  always_comb begin
    en[QB-1] = !v_q[QB-1] || ready_i;
    for (int k = QB - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k + 1];
    end
  end
  assign ready_o = en[0];

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int B = QB - 1 - k;
    logic           vp, hp, sp;
    logic [RW-1:0]  rp, sh;
    logic [AMW-1:0] dp;
    logic [TW-1:0]  qp;

    if (k == 0) begin : g_first
      assign vp = valid_i;
      assign hp = hit_i;
      assign sp = sat_i;
      assign rp = rem_i;
      assign dp = div_i;
      assign qp = '0;
    end else begin : g_next
      assign vp = v_q[k - 1];
      assign hp = hit_q[k - 1];
      assign sp = sat_q[k - 1];
      assign rp = rem_q[k - 1];
      assign dp = dv_q[k - 1];
      assign qp = quo_q[k - 1];
    end

    assign sh = RW'(dp) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= vp;
      end
    end

    // Subtract the shifted divisor when it fits and set this quotient bit.
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        hit_q[k] <= hp;
        sat_q[k] <= sp;
        dv_q[k]  <= dp;
        if (rp >= sh) begin
          rem_q[k] <= rp - sh;
          quo_q[k] <= qp | (TW'(1) << B);
        end else begin
          rem_q[k] <= rp;
          quo_q[k] <= qp;
        end
      end
    end
  end

  // Misses read zero; a quotient beyond the range reads the maximum.
  assign valid_o = v_q[QB-1];
  assign hit_o   = hit_q[QB-1];
  assign dist_o  = !hit_q[QB-1] ? '0 : (sat_q[QB-1] ? HIT_MAX : quo_q[QB-1]);

endmodule

>>> hw/rtl/ray_triangle_intersect.sv
// Top level of the ray/triangle intersection pipeline.
// Tests one triangle per item against the configured ray (Moller-Trumbore, exact
// fixed point). One item enters per clock while the output does not stall; each
// item passes through three stages of edges and cross products, three of dot
// products, three of tests, and 31 stages of the restoring divider that
// produces the distance one bit per stage. Stalls at the output back up the
// pipeline without losing items; empty stages are filled while the output waits.
// Configuration registers must be written only while no item is in flight.
`include "ray_triangle_intersect_defines.svh"

module ray_triangle_intersect import rti_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  rti_cfg_if.sink cfg_i,
  rti_tri_if.sink tri_i,
  rti_hit_if.source res_o
);

  ray_cfg_t cfg_q;
  cw3_t     v0, v1, v2;

  logic fr_valid, fr_ready;
  ev3_t e1, e2, s;
  xv3_t h, q;
  logic dt_valid, dt_ready;
  dv_t  det, un, vn, tn;
  logic ts_valid, ts_ready;
  logic ts_hit, ts_sat;
  logic [RW-1:0]  ts_rem;
  logic [AMW-1:0] ts_div;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{org: '0, dir: {cw_t'(1 << FB), cw_t'(0), cw_t'(0)}, thr: TW'(1)};
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_ORIGIN_X:  cfg_q.org[0] <= cfg_i.data;
        CFG_ORIGIN_Y:  cfg_q.org[1] <= cfg_i.data;
        CFG_ORIGIN_Z:  cfg_q.org[2] <= cfg_i.data;
        CFG_DIR_X:     cfg_q.dir[0] <= cfg_i.data;
        CFG_DIR_Y:     cfg_q.dir[1] <= cfg_i.data;
        CFG_DIR_Z:     cfg_q.dir[2] <= cfg_i.data;
        CFG_THRESHOLD: cfg_q.thr    <= cfg_i.data[TW-1:0];
        default: ;
      endcase
    end
  end

  // Vertex fields gathered into vectors.
  assign v0 = {tri_i.vert0_z, tri_i.vert0_y, tri_i.vert0_x};
  assign v1 = {tri_i.vert1_z, tri_i.vert1_y, tri_i.vert1_x};
  assign v2 = {tri_i.vert2_z, tri_i.vert2_y, tri_i.vert2_x};

  rti_front u_front (
    .clk_i, .rst_ni,
    .valid_i (tri_i.valid), .ready_o (tri_i.ready),
    .v0_i (v0), .v1_i (v1), .v2_i (v2), .cfg_i (cfg_q),
    .valid_o (fr_valid), .ready_i (fr_ready),
    .e1_o (e1), .e2_o (e2), .s_o (s), .h_o (h), .q_o (q)
  );

  rti_dot u_dot (
    .clk_i, .rst_ni,
    .valid_i (fr_valid), .ready_o (fr_ready),
    .e1_i (e1), .e2_i (e2), .s_i (s), .h_i (h), .q_i (q), .dir_i (cfg_q.dir),
    .valid_o (dt_valid), .ready_i (dt_ready),
    .det_o (det), .un_o (un), .vn_o (vn), .tn_o (tn)
  );

  rti_test u_test (
    .clk_i, .rst_ni,
    .valid_i (dt_valid), .ready_o (dt_ready),
    .det_i (det), .un_i (un), .vn_i (vn), .tn_i (tn), .thr_i (cfg_q.thr),
    .valid_o (ts_valid), .ready_i (ts_ready),
    .hit_o (ts_hit), .sat_o (ts_sat), .rem_o (ts_rem), .div_o (ts_div)
  );

  rti_div u_div (
    .clk_i, .rst_ni,
    .valid_i (ts_valid), .ready_o (ts_ready),
    .hit_i (ts_hit), .sat_i (ts_sat), .rem_i (ts_rem), .div_i (ts_div),
    .valid_o (res_o.valid), .ready_i (res_o.ready),
    .hit_o (res_o.hit), .dist_o (res_o.hit_distance)
  );

  // A miss carries no distance.
  `RTI_ASSERT(a_miss_zero, res_o.valid && !res_o.hit |-> res_o.hit_distance == '0, "miss with distance")
  // The input is refused only when the whole pipeline is backed up by the output.
  `RTI_ASSERT(a_backpressure, !tri_i.ready |-> res_o.valid && !res_o.ready, "input stalled without output stall")
  // A waiting result holds its distance until it is taken.
  `RTI_ASSERT(a_result_hold, res_o.valid && !res_o.ready |=> res_o.valid && $stable(res_o.hit_distance), "result changed while waiting")
  // Configuration writes are never refused.
  `RTI_ASSERT_ALWAYS(a_cfg_ready, cfg_i.ready == 1'b1, "configuration port not ready")

endmodule
